### design/dlefd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlefd_pkg
// Shared constants and types of the DLE framed message deframer.
// ----------------------------------------------------------------------------
package dlefd_pkg;

   localparam int BUF_LEN  = 256;
   localparam int MAX_DATA = 223;
   localparam int AW       = $clog2(BUF_LEN);
   localparam int WP_W     = $clog2(BUF_LEN + 1);
   localparam int CMP_W    = (WP_W > 10) ? WP_W : 10;
   localparam int HDR_MAX  = 13;
   localparam int WIDX_W   = 5;

   localparam logic [7:0] DLE       = 8'h10;
   localparam logic [7:0] STX       = 8'h02;
   localparam logic [7:0] ETX       = 8'h03;
   localparam logic [7:0] TYPE_DATA = 8'h93;
   localparam logic [7:0] TYPE_REQ  = 8'h94;

   localparam logic [3:0] HDR_END_DATA = 4'd13;
   localparam logic [3:0] HDR_END_REQ  = 4'd8;

   localparam logic [7:0] DEFAULT_SOURCE_RST = 8'd65;

   typedef struct packed {
      logic          en;
      logic [AW-1:0] addr;
      logic [7:0]    data;
   } wr_type;

   typedef struct packed {
      logic            ok;
      logic [7:0]      prio;
      logic [23:0]     pgn;
      logic [7:0]      dest;
      logic [7:0]      src;
      logic [31:0]     tm;
      logic [7:0]      dlen;
      logic [3:0]      hdr_end;
      logic [WP_W-1:0] n;
   } frame_type;

endpackage
`default_nettype wire

### design/dlefd_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlefd_parser
// Byte-level DLE/STX/ETX framing, body store writes, checksum and header
// capture, and the end-of-frame validity check.
// ----------------------------------------------------------------------------
module dlefd_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               byte_valid,
   input  wire logic [7:0]         rx_byte,
   input  wire logic [31:0]        now_ms,
   input  wire logic [7:0]         default_source,
   output dlefd_pkg::wr_type       wr,
   output dlefd_pkg::frame_type    fin
);

   logic [dlefd_pkg::WP_W-1:0] wp_ff, wp_in;
   logic [7:0]                 sum_ff, sum_in;
   logic                       start_ff, start_in;
   logic                       inmsg_ff, inmsg_in;
   logic                       esc_ff, esc_in;
   logic [7:0]                 last_ff;
   logic [7:0]                 hdr_ff [0:dlefd_pkg::HDR_MAX-1];

   logic do_store, do_clear, do_start, do_finish;
   logic full, store_ok, skip_sum;
   logic [dlefd_pkg::CMP_W-1:0] wp_c, len3_c;
   logic is_data, is_req;
   logic [7:0] dlen;
   logic [3:0] hdr_end;

   assign wp_c     = dlefd_pkg::CMP_W'(wp_ff);
   assign full     = (wp_ff == dlefd_pkg::WP_W'(dlefd_pkg::BUF_LEN));
   assign store_ok = do_store && !full;
   // checksum byte sits at body index length + 2
   assign skip_sum = (wp_c >= dlefd_pkg::CMP_W'(2))
                     && (wp_c == dlefd_pkg::CMP_W'(hdr_ff[1]) + dlefd_pkg::CMP_W'(2));

   always_comb begin
      wp_in     = wp_ff;
      sum_in    = sum_ff;
      start_in  = start_ff;
      inmsg_in  = inmsg_ff;
      esc_in    = esc_ff;
      do_store  = 1'b0;
      do_clear  = 1'b0;
      do_start  = 1'b0;
      do_finish = 1'b0;
      if (byte_valid) begin
         if (inmsg_ff) begin
            if (esc_ff) begin
               if (rx_byte == dlefd_pkg::DLE) begin
                  esc_in   = 1'b0;
                  do_store = 1'b1;
               end else if (rx_byte == dlefd_pkg::ETX) begin
                  do_finish = 1'b1;
                  do_clear  = 1'b1;
               end else if (rx_byte == dlefd_pkg::STX) begin
                  do_clear = 1'b1;
                  do_start = 1'b1;
               end else begin
                  do_clear = 1'b1;
               end
            end else if (rx_byte == dlefd_pkg::DLE) begin
               esc_in = 1'b1;
            end else begin
               do_store = 1'b1;
            end
         end else if (rx_byte == dlefd_pkg::STX) begin
            start_in = 1'b0;
            if (esc_ff) begin
               do_clear = 1'b1;
               do_start = 1'b1;
            end
         end else begin
            esc_in = (rx_byte == dlefd_pkg::DLE);
            if (start_ff) begin
               start_in = 1'b0;
               inmsg_in = 1'b1;
               do_store = 1'b1;
            end
         end
      end
      if (store_ok) begin
         wp_in = wp_ff + dlefd_pkg::WP_W'(1);
         if (!skip_sum) begin
            sum_in = sum_ff + rx_byte;
         end
      end
      if (do_clear || (do_store && full)) begin
         wp_in    = '0;
         sum_in   = '0;
         start_in = 1'b0;
         inmsg_in = 1'b0;
         esc_in   = 1'b0;
      end
      if (do_start) begin
         start_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         sum_ff   <= '0;
         start_ff <= 1'b0;
         inmsg_ff <= 1'b0;
         esc_ff   <= 1'b0;
      end else begin
         wp_ff    <= wp_in;
         sum_ff   <= sum_in;
         start_ff <= start_in;
         inmsg_ff <= inmsg_in;
         esc_ff   <= esc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_ok) begin
         last_ff <= rx_byte;
      end
   end

   for (genvar k = 0; k < dlefd_pkg::HDR_MAX; k++) begin : g_hdr
      always_ff @(posedge clock) begin
         if (store_ok && (wp_ff == dlefd_pkg::WP_W'(k))) begin
            hdr_ff[k] <= rx_byte;
         end
      end
   end

   assign wr.en   = store_ok;
   assign wr.addr = wp_ff[dlefd_pkg::AW-1:0];
   assign wr.data = rx_byte;

   assign is_data = (hdr_ff[0] == dlefd_pkg::TYPE_DATA);
   assign is_req  = (hdr_ff[0] == dlefd_pkg::TYPE_REQ);
   assign len3_c  = dlefd_pkg::CMP_W'(hdr_ff[1]) + dlefd_pkg::CMP_W'(3);
   assign hdr_end = is_data ? dlefd_pkg::HDR_END_DATA : dlefd_pkg::HDR_END_REQ;
   assign dlen    = is_data ? hdr_ff[12] : hdr_ff[7];

   assign fin.ok = do_finish
                   && (wp_c >= dlefd_pkg::CMP_W'(2))
                   && (is_data || is_req)
                   && (wp_c == len3_c)
                   && ((8'd0 - sum_ff) == last_ff)
                   && (wp_c >= dlefd_pkg::CMP_W'(hdr_end))
                   && (dlen <= 8'(dlefd_pkg::MAX_DATA));
   assign fin.prio    = hdr_ff[2];
   assign fin.pgn     = {hdr_ff[5], hdr_ff[4], hdr_ff[3]};
   assign fin.dest    = hdr_ff[6];
   assign fin.src     = is_data ? hdr_ff[7] : default_source;
   assign fin.tm      = is_data ? {hdr_ff[11], hdr_ff[10], hdr_ff[9], hdr_ff[8]} : now_ms;
   assign fin.dlen    = dlen;
   assign fin.hdr_end = hdr_end;
   assign fin.n       = wp_ff;

endmodule
`default_nettype wire

### design/dle_framed_message_deframer_top.sv
// a non-final request is absorbed by the parser; one request per cycle while the drain sequencer is idle
// an end-of-frame request of a valid message yields its words one after another, each made by:
//   8 single-byte reads of the frame memory, a fill state, one output load
// the next request is taken once the last word sits in the output register
// reset is synchronous; it clears control state, the frame memory is not cleared
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dle_framed_message_deframer_top
// DLE framed message deframer: parser, frame body memory, word drain sequencer and
// output register.
// ----------------------------------------------------------------------------
module dle_framed_message_deframer_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic [31:0] req_now_ms,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_priority_res,
   output logic [23:0]      rsp_pgn,
   output logic [7:0]       rsp_destination,
   output logic [7:0]       rsp_source,
   output logic [31:0]      rsp_msg_time,
   output logic [7:0]       rsp_data_len,
   output logic [63:0]      rsp_data_word,
   output logic [4:0]       rsp_word_index,
   output logic             rsp_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_default_source
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_READ = 4'b0010,
      S_FILL = 4'b0100,
      S_EMIT = 4'b1000
   } drain_state_type;

   drain_state_type state_ff, state_in;

   logic [7:0] src_ff;
   logic       req_accept;

   dlefd_pkg::wr_type    wr;
   dlefd_pkg::frame_type fin;
   dlefd_pkg::frame_type desc_ff;

   logic [7:0]                    frame_mem [0:dlefd_pkg::BUF_LEN-1];
   logic [7:0]                    rd_data_ff;
   logic [dlefd_pkg::AW-1:0]      rd_addr;
   logic [dlefd_pkg::CMP_W-1:0]   pay_addr;
   logic                          rd_use;

   logic [7:0]                    bi_ff, bi_in;
   logic [dlefd_pkg::WIDX_W-1:0]  widx_ff, widx_in;
   logic [dlefd_pkg::WIDX_W-1:0]  words_m1_ff, words_m1_in;
   logic                          pend_ff, pend_in;
   logic                          pend_use_ff;
   logic [2:0]                    pend_lane_ff;
   logic [7:0]                    word_ff [0:7];
   logic [63:0]                   word_flat;

   logic rsp_valid_ff, rsp_valid_in;
   logic load;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_ff <= dlefd_pkg::DEFAULT_SOURCE_RST;
      end else if (csr_valid) begin
         src_ff <= csr_default_source;
      end
   end

   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid && req_ready;

   dlefd_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .byte_valid     (req_accept),
      .rx_byte        (req_rx_byte),
      .now_ms         (req_now_ms),
      .default_source (src_ff),
      .wr             (wr),
      .fin            (fin)
   );

   // frame body memory
   assign pay_addr = dlefd_pkg::CMP_W'(desc_ff.hdr_end) + dlefd_pkg::CMP_W'(bi_ff);
   assign rd_addr  = pay_addr[dlefd_pkg::AW-1:0];
   assign rd_use   = (bi_ff < desc_ff.dlen)
                     && (pay_addr < dlefd_pkg::CMP_W'(desc_ff.n) - dlefd_pkg::CMP_W'(1));

   always_ff @(posedge clock) begin
      if (wr.en) begin
         frame_mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= frame_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (pend_ff) begin
         word_ff[pend_lane_ff] <= pend_use_ff ? rd_data_ff : 8'd0;
      end
   end

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         word_flat[8*k +: 8] = word_ff[k];
      end
   end

   assign load = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_ready);

   // drain sequencer
   always_comb begin
      state_in    = state_ff;
      bi_in       = bi_ff;
      widx_in     = widx_ff;
      words_m1_in = words_m1_ff;
      pend_in     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_accept && fin.ok) begin
               state_in    = S_READ;
               bi_in       = '0;
               widx_in     = '0;
               words_m1_in = (fin.dlen == 8'd0) ? '0
                             : dlefd_pkg::WIDX_W'((fin.dlen - 8'd1) >> 3);
            end
         end
         S_READ: begin
            pend_in = 1'b1;
            bi_in   = bi_ff + 8'd1;
            if (bi_ff[2:0] == 3'd7) begin
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (load) begin
               if (widx_ff == words_m1_ff) begin
                  state_in = S_IDLE;
               end else begin
                  widx_in  = widx_ff + dlefd_pkg::WIDX_W'(1);
                  state_in = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      bi_ff        <= bi_in;
      widx_ff      <= widx_in;
      words_m1_ff  <= words_m1_in;
      pend_use_ff  <= rd_use;
      pend_lane_ff <= bi_ff[2:0];
      if (state_ff == S_IDLE && req_accept && fin.ok) begin
         desc_ff <= fin;
      end
   end

   // output register
   assign rsp_valid_in = (rsp_valid_ff && !rsp_ready) || load;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_priority_res <= desc_ff.prio;
         rsp_pgn          <= desc_ff.pgn;
         rsp_destination  <= desc_ff.dest;
         rsp_source       <= desc_ff.src;
         rsp_msg_time     <= desc_ff.tm;
         rsp_data_len     <= desc_ff.dlen;
         rsp_data_word    <= word_flat;
         rsp_word_index   <= widx_ff;
         rsp_last         <= (widx_ff == words_m1_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   a_no_write_in_drain : assert property (@(posedge clock) disable iff (reset)
      wr.en |-> (state_ff == S_IDLE))
      else $error("frame memory written during drain");

   a_last_matches_len : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_word_index == ((rsp_data_len == 8'd0) ? 5'd0
                     : 5'((rsp_data_len - 8'd1) >> 3)))))
      else $error("last flag disagrees with data length");

   a_len_in_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data_len <= 8'(dlefd_pkg::MAX_DATA)))
      else $error("data length above maximum");

   a_read_to_fill : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) && (bi_ff[2:0] == 3'd7) |=> (state_ff == S_FILL))
      else $error("word read did not end after eight bytes");
`endif

endmodule
`default_nettype wire
